### rtl/core/haar2x2_pkg.sv
// Shared types and constants for the 2x2 Haar analysis block.
package haar2x2_pkg;

    localparam logic [1:0] CH_ALPHA    = 2'd3;
    localparam int         ABS_W       = 40;
    localparam int         SQ_W        = 58;
    localparam int         MAG_W       = 19;
    localparam int         SQM_W       = 2 * MAG_W;
    localparam int         LVL_W       = 27;
    localparam int         LVL_SHIFT   = 14;
    localparam logic [LVL_W-1:0] LVL_ROUND = LVL_W'(8192);
    localparam logic [7:0] LEVEL_MAX   = 8'd255;

    // Transform word passed from the front end to the back end
    typedef struct packed {
        logic signed [15:0] quad_average;
        logic signed [16:0] vertical_detail;
        logic signed [16:0] horizontal_detail;
        logic signed [17:0] diagonal_detail;
        logic        [1:0]  channel;
        logic               level_start;
    } quad_word_t;

endpackage

### rtl/core/haar2x2_front.sv
// Front end: accepts quads, runs the Haar butterflies and registers the word.
module haar2x2_front
    import haar2x2_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] top_left,
    input  logic signed [15:0] top_right,
    input  logic signed [15:0] bottom_left,
    input  logic signed [15:0] bottom_right,
    input  logic        [1:0]  channel,
    input  logic               level_start,
    output logic               q_push,
    output quad_word_t         q_wdata,
    input  logic               q_full
);

    logic               valid_reg;
    logic               valid_next;
    quad_word_t         word_reg;
    quad_word_t         word_next;
    logic               load;
    logic               drain;

    logic signed [16:0] sum_ab;
    logic signed [16:0] sum_cd;
    logic signed [16:0] dif_ab;
    logic signed [16:0] dif_cd;
    logic signed [15:0] half_ab;
    logic signed [15:0] half_cd;
    logic signed [16:0] sum_halves;
    logic signed [17:0] sum_difs;

    // Row sums and differences; floor halving drops the low bit
    always_comb
    begin
        sum_ab     = {top_left[15], top_left} + {top_right[15], top_right};
        sum_cd     = {bottom_left[15], bottom_left} + {bottom_right[15], bottom_right};
        dif_ab     = {top_left[15], top_left} - {top_right[15], top_right};
        dif_cd     = {bottom_left[15], bottom_left} - {bottom_right[15], bottom_right};
        half_ab    = sum_ab[16:1];
        half_cd    = sum_cd[16:1];
        sum_halves = {half_ab[15], half_ab} + {half_cd[15], half_cd};
        sum_difs   = {dif_ab[16], dif_ab} + {dif_cd[16], dif_cd};

        word_next.quad_average      = sum_halves[16:1];
        word_next.vertical_detail   = {half_ab[15], half_ab} - {half_cd[15], half_cd};
        word_next.horizontal_detail = sum_difs[17:1];
        word_next.diagonal_detail   = {dif_ab[16], dif_ab} - {dif_cd[16], dif_cd};
        word_next.channel           = channel;
        word_next.level_start       = level_start;
    end

    // Hold the word until the queue takes it
    assign drain = valid_reg && !q_full;
    assign full  = valid_reg && q_full;
    assign load  = push && !full;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (drain)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

    assign q_push  = valid_reg;
    assign q_wdata = word_reg;

endmodule

### rtl/core/haar2x2_queue.sv
// Small first-in first-out queue of transform words between front and back.
module haar2x2_queue
    import haar2x2_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  quad_word_t wdata,
    output logic       full,
    input  logic       pop,
    output quad_word_t rdata,
    output logic       empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    quad_word_t      mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### rtl/core/haar2x2_back.sv
// Back end: magnitude, square, detail level, channel totals and result register.
module haar2x2_back
    import haar2x2_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  quad_word_t          q_rdata,
    output logic                q_pop,
    output logic signed [15:0]  quad_average,
    output logic signed [16:0]  vertical_detail,
    output logic signed [16:0]  horizontal_detail,
    output logic signed [17:0]  diagonal_detail,
    output logic        [7:0]   detail_level,
    output logic        [ABS_W-1:0] abs_total,
    output logic        [SQ_W-1:0]  square_total,
    output logic                empty,
    input  logic                pop
);

    // Pipeline stage valids and handshakes
    logic                 a_valid_reg;
    logic                 b_valid_reg;
    logic                 o_valid_reg;
    logic                 a_valid_next;
    logic                 b_valid_next;
    logic                 o_valid_next;
    logic                 o_ready;
    logic                 b_ready;
    logic                 a_ready;
    logic                 a_load;
    logic                 b_load;
    logic                 o_load;

    quad_word_t           a_word_reg;
    logic [MAG_W-1:0]     a_mag_reg;
    quad_word_t           b_word_reg;
    logic [MAG_W-1:0]     b_mag_reg;
    logic [SQM_W-1:0]     b_sq_reg;

    logic [ABS_W-1:0]     mag_sums_reg [3];
    logic [SQ_W-1:0]      sq_sums_reg  [3];

    // Result register
    logic signed [15:0]   quad_average_reg;
    logic signed [16:0]   vertical_detail_reg;
    logic signed [16:0]   horizontal_detail_reg;
    logic signed [17:0]   diagonal_detail_reg;
    logic        [7:0]    detail_level_reg;
    logic [ABS_W-1:0]     abs_total_reg;
    logic [SQ_W-1:0]      square_total_reg;

    logic [16:0]          abs_vert;
    logic [16:0]          abs_horz;
    logic [17:0]          abs_diag;
    logic [MAG_W-1:0]     mag_next;

    logic [LVL_W-1:0]     lvl_wide;
    logic [LVL_W-LVL_SHIFT-1:0] lvl_q;
    logic [7:0]           lvl_sat;
    logic                 is_alpha;
    logic [ABS_W-1:0]     mag_cur;
    logic [SQ_W-1:0]      sq_cur;
    logic [ABS_W:0]       mag_sum;
    logic [SQ_W:0]        sq_sum;
    logic [ABS_W-1:0]     mag_new;
    logic [SQ_W-1:0]      sq_new;

    assign o_ready = !o_valid_reg || pop;
    assign b_ready = !b_valid_reg || o_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign q_pop   = !q_empty && a_ready;
    assign a_load  = q_pop;
    assign b_load  = a_valid_reg && b_ready;
    assign o_load  = b_valid_reg && o_ready;
    assign empty   = !o_valid_reg;

    // Stage A: magnitude of the three details
    always_comb
    begin
        abs_vert = q_rdata.vertical_detail[16]
                 ? 17'(-q_rdata.vertical_detail) : 17'(q_rdata.vertical_detail);
        abs_horz = q_rdata.horizontal_detail[16]
                 ? 17'(-q_rdata.horizontal_detail) : 17'(q_rdata.horizontal_detail);
        abs_diag = q_rdata.diagonal_detail[17]
                 ? 18'(-q_rdata.diagonal_detail) : 18'(q_rdata.diagonal_detail);
        mag_next = MAG_W'(abs_vert) + MAG_W'(abs_horz) + MAG_W'(abs_diag);
    end

    // Stage C: byte level, rounded and saturated
    always_comb
    begin
        lvl_wide = (LVL_W'(b_mag_reg) << 8) - LVL_W'(b_mag_reg) + LVL_ROUND;
        lvl_q    = lvl_wide[LVL_W-1:LVL_SHIFT];
        lvl_sat  = (|lvl_q[LVL_W-LVL_SHIFT-1:8]) ? LEVEL_MAX : lvl_q[7:0];
    end

    // Stage C: saturating total update, level start clears first
    always_comb
    begin
        is_alpha = (b_word_reg.channel == CH_ALPHA);
        mag_cur  = '0;
        sq_cur   = '0;
        if (!is_alpha && !b_word_reg.level_start)
        begin
            mag_cur = mag_sums_reg[b_word_reg.channel];
            sq_cur  = sq_sums_reg[b_word_reg.channel];
        end
        mag_sum = {1'b0, mag_cur} + (ABS_W + 1)'(b_mag_reg);
        sq_sum  = {1'b0, sq_cur} + (SQ_W + 1)'(b_sq_reg);
        mag_new = mag_sum[ABS_W] ? '1 : mag_sum[ABS_W-1:0];
        sq_new  = sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
    end

    // Advance stage valids
    always_comb
    begin
        a_valid_next = a_load ? 1'b1 : (b_load ? 1'b0 : a_valid_reg);
        b_valid_next = b_load ? 1'b1 : (o_load ? 1'b0 : b_valid_reg);
        o_valid_next = o_load ? 1'b1 : (pop ? 1'b0 : o_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // Hold or update channel totals; the word's own channel takes the new
    // total, the others clear on a level start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_sums_reg[i] <= '0;
                sq_sums_reg[i]  <= '0;
            end
        end
        else if (o_load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (!is_alpha && (b_word_reg.channel == 2'(i)))
                begin
                    mag_sums_reg[i] <= mag_new;
                    sq_sums_reg[i]  <= sq_new;
                end
                else if (b_word_reg.level_start)
                begin
                    mag_sums_reg[i] <= '0;
                    sq_sums_reg[i]  <= '0;
                end
            end
        end
    end

    // Payload registers of the three stages
    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_word_reg <= q_rdata;
            a_mag_reg  <= mag_next;
        end
        if (b_load)
        begin
            b_word_reg <= a_word_reg;
            b_mag_reg  <= a_mag_reg;
            b_sq_reg   <= a_mag_reg * a_mag_reg;
        end
        if (o_load)
        begin
            quad_average_reg      <= b_word_reg.quad_average;
            vertical_detail_reg   <= b_word_reg.vertical_detail;
            horizontal_detail_reg <= b_word_reg.horizontal_detail;
            diagonal_detail_reg   <= b_word_reg.diagonal_detail;
            detail_level_reg      <= is_alpha ? LEVEL_MAX : lvl_sat;
            abs_total_reg         <= is_alpha ? '0 : mag_new;
            square_total_reg      <= is_alpha ? '0 : sq_new;
        end
    end

    assign quad_average      = quad_average_reg;
    assign vertical_detail   = vertical_detail_reg;
    assign horizontal_detail = horizontal_detail_reg;
    assign diagonal_detail   = diagonal_detail_reg;
    assign detail_level      = detail_level_reg;
    assign abs_total         = abs_total_reg;
    assign square_total      = square_total_reg;

endmodule

### rtl/core/haar_2x2_analysis_with_stats.sv
// Top level of the 2x2 Haar analysis block with per-channel detail totals.
//
// Input side is a queue write port: drive the four Q1.14 samples, channel and
// level_start with push; the word is taken on a clock edge where push is high
// and full is low. Result side is a queue read port: while empty is low the
// oldest result sits on the output ports and is taken on an edge with pop high.
// One quad is accepted every cycle and one result leaves every cycle when the
// receiver pops continuously. A result first shows on the output ports after its
// word is taken and has passed the front register, queue slot, magnitude stage,
// square stage, then the result register where the channel totals update.
// The rate is one word per cycle while pop stays high, set by the saturating
// update of the running totals in the last back-end stage.
// When pop stays low, results pile up in the back-end stages, the middle queue
// and the front register; full rises once all are occupied and drops as soon as room frees.
// Reset clears all running totals to zero and empties every stage and the queue.
module haar_2x2_analysis_with_stats
    import haar2x2_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic signed [15:0]     top_left,
    input  logic signed [15:0]     top_right,
    input  logic signed [15:0]     bottom_left,
    input  logic signed [15:0]     bottom_right,
    input  logic        [1:0]      channel,
    input  logic                   level_start,
    output logic                   empty,
    input  logic                   pop,
    output logic signed [15:0]     quad_average,
    output logic signed [16:0]     vertical_detail,
    output logic signed [16:0]     horizontal_detail,
    output logic signed [17:0]     diagonal_detail,
    output logic        [7:0]      detail_level,
    output logic        [ABS_W-1:0] abs_total,
    output logic        [SQ_W-1:0]  square_total
);

    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    quad_word_t q_wdata;
    quad_word_t q_rdata;

    haar2x2_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .top_left     (top_left),
        .top_right    (top_right),
        .bottom_left  (bottom_left),
        .bottom_right (bottom_right),
        .channel      (channel),
        .level_start  (level_start),
        .q_push       (q_push),
        .q_wdata      (q_wdata),
        .q_full       (q_full)
    );

    haar2x2_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    haar2x2_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_empty           (q_empty),
        .q_rdata           (q_rdata),
        .q_pop             (q_pop),
        .quad_average      (quad_average),
        .vertical_detail   (vertical_detail),
        .horizontal_detail (horizontal_detail),
        .diagonal_detail   (diagonal_detail),
        .detail_level      (detail_level),
        .abs_total         (abs_total),
        .square_total      (square_total),
        .empty             (empty),
        .pop               (pop)
    );

endmodule
